@@ rtl/aid_pkg.sv @@
// Shared types and constants of the allpass interpolated delay unit.
package aid_pkg;

  localparam int unsigned DELAY_W = 20;
  localparam int unsigned GAIN_W  = 16;

  localparam logic [DELAY_W-1:0]       DELAY_MIN_Q8 = 20'd256;
  localparam logic signed [GAIN_W-1:0] GAIN_LIMIT   = 16'sd31129;

  // Register indexes on the configuration port
  localparam logic REG_DELAY = 1'b0;
  localparam logic REG_GAIN  = 1'b1;

  typedef struct packed {
    logic [DELAY_W-1:0]       delay_q8;
    logic signed [GAIN_W-1:0] gain;
  } aid_cfg_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RDB  = 5'b00010,
    S_INT  = 5'b00100,
    S_GAIN = 5'b01000,
    S_OUT  = 5'b10000
  } aid_state_t;

endpackage

@@ rtl/aid_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module aid_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/aid_regs.sv @@
// Configuration register file: delay and gain, clamped on write.
module aid_regs
  import aid_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output aid_cfg_t    cfg
);

  localparam longint MAXQ_L = ((longint'(RING_DEPTH) - 1) * 256 > 64'hFFFFF) ?
                              64'hFFFFF : (longint'(RING_DEPTH) - 1) * 256;
  localparam logic [DELAY_W-1:0] MAXQ = DELAY_W'(MAXQ_L);

  aid_cfg_t                 cfg_r;
  aid_cfg_t                 cfg_nxt;
  logic                     wr_en;
  logic [DELAY_W-1:0]       dly_wr;
  logic signed [GAIN_W-1:0] gain_wr;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign dly_wr     = cfg_pwdata[DELAY_W-1:0];
  assign gain_wr    = cfg_pwdata[GAIN_W-1:0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_paddr[2])
        REG_DELAY: begin
          if (dly_wr < DELAY_MIN_Q8) begin
            cfg_nxt.delay_q8 = DELAY_MIN_Q8;
          end else if (dly_wr > MAXQ) begin
            cfg_nxt.delay_q8 = MAXQ;
          end else begin
            cfg_nxt.delay_q8 = dly_wr;
          end
        end
        REG_GAIN: begin
          if (gain_wr > GAIN_LIMIT) begin
            cfg_nxt.gain = GAIN_LIMIT;
          end else if (gain_wr < -GAIN_LIMIT) begin
            cfg_nxt.gain = -GAIN_LIMIT;
          end else begin
            cfg_nxt.gain = gain_wr;
          end
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_q8 <= DELAY_MIN_Q8;
      cfg_r.gain     <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_DELAY: cfg_prdata = 32'(cfg_r.delay_q8);
      REG_GAIN:  cfg_prdata = 32'(cfg_r.gain);
      default:   cfg_prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/allpass_interp_delay_unit.sv @@
// Top level of the allpass section with a linearly interpolated fractional delay.
//
// Use: samples enter on the in_ stream and one allpass output leaves on the
// out_ stream per accepted transaction. Delay (unsigned Q12.8) and gain
// (signed Q1.15) are set over the cfg_ APB port while the unit is idle; both
// are clamped on write and read back as clamped.
// Timing: an input transaction is taken only in the idle state. The two ring
// taps are read one after the other through the single read port of the ring
// memory, then interpolation, the feedback multiply and the write-back follow.
// The result is offered after the write-back, and the next sample is taken
// only once the unit is back in idle; the ring memory read port and the two
// gain multiplies, each in a state of its own, set the length of the sequence.
// Stall: a finished result waits in the output register while the next sample
// is already accepted; the write-back stage holds until that register frees.
// Reset: the write pointer goes to zero and a wrap flag is cleared. Ring
// entries not yet written since reset read as zero (below the write pointer
// before the first wrap), so no clearing pass is run and the unit is ready
// as soon as reset is released.
module allpass_interp_delay_unit
  import aid_pkg::*;
#(
  parameter int unsigned RING_DEPTH  = 4096,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: [SAMPLE_BITS-1:0] sample_in, zero padding above
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] in_tdata,
  // out_tdata: [SAMPLE_BITS-1:0] sample_out, zero padding above
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] out_tdata,
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [2:0]                            cfg_paddr,
  input  logic [31:0]                           cfg_pwdata,
  output logic [31:0]                           cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int unsigned SB  = SAMPLE_BITS;
  localparam int unsigned TDW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned AW  = $clog2(RING_DEPTH);
  localparam int unsigned PW  = ((AW > 12) ? AW : 12) + 1;

  aid_cfg_t cfg;

  aid_state_t state_r, state_nxt;
  logic [AW-1:0] wr_idx_r, wr_idx_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic          out_valid_r, out_valid_nxt;

  // Datapath registers (no reset)
  logic signed [SB-1:0] x_r;
  logic signed [SB-1:0] a_r;
  logic signed [SB-1:0] delayed_r;
  logic signed [SB:0]   px_r;
  logic signed [SB:0]   gd_r;
  logic [SB-1:0]        y_r;
  logic [SB-1:0]        out_data_r;
  logic [AW-1:0]        p2_r;
  logic                 va_r;
  logic                 vb_r;

  logic                    accept;
  logic                    slot_free;
  logic                    ram_we;
  logic [AW-1:0]           rd_addr;
  logic [SB-1:0]           rd_data;
  logic [SB-1:0]           w_c;
  logic [11:0]             d_int;
  logic [7:0]              d_frac;
  logic [PW-1:0]           p1_diff;
  logic [PW-1:0]           p1_full;
  logic [AW-1:0]           p1_c;
  logic [AW-1:0]           p2_c;
  logic signed [SB-1:0]    b_c;
  logic signed [SB:0]      ab_diff;
  logic signed [8:0]       frac_s;
  logic signed [SB+9:0]    ip_prod;
  logic signed [SB+10:0]   acc_c;
  logic signed [SB+15:0]   px_rnd;
  logic signed [SB+15:0]   gd_rnd;

  function automatic logic [SB-1:0] sat(input logic signed [SB+1:0] v);
    if (v[SB+1:SB-1] == 3'b000 || v[SB+1:SB-1] == 3'b111) begin
      return v[SB-1:0];
    end else if (v[SB+1]) begin
      return {1'b1, {(SB-1){1'b0}}};
    end else begin
      return {1'b0, {(SB-1){1'b1}}};
    end
  endfunction

  aid_regs #(
    .RING_DEPTH(RING_DEPTH)
  ) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .cfg        (cfg)
  );

  aid_ram #(
    .WIDTH(SB),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_idx_r),
    .wdata(w_c),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Handshakes
  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign ram_we     = (state_r == S_OUT) && slot_free;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDW'(out_data_r);

  // Tap addresses: write pointer minus the integer delay, and one further back
  assign d_int   = cfg.delay_q8[19:8];
  assign d_frac  = cfg.delay_q8[7:0];
  assign p1_diff = PW'(wr_idx_r) - PW'(d_int);
  assign p1_full = p1_diff[PW-1] ? (p1_diff + PW'(RING_DEPTH)) : p1_diff;
  assign p1_c    = p1_full[AW-1:0];
  assign p2_c    = (p1_c == '0) ? AW'(RING_DEPTH - 1) : (p1_c - AW'(1));

  // First tap is addressed on the accepting edge, the second one in the following S_RDB state
  assign rd_addr = (state_r == S_IDLE) ? p1_c : p2_r;

  // Interpolation: a*256 + (b - a)*f + 128, then drop eight bits
  assign b_c     = vb_r ? signed'(rd_data) : '0;
  assign ab_diff = (SB+1)'(b_c) - (SB+1)'(a_r);
  assign frac_s  = $signed({1'b0, d_frac});
  assign ip_prod = ab_diff * frac_s;
  assign acc_c   = ((SB+11)'(a_r) <<< 8) + (SB+11)'(ip_prod) + (SB+11)'(128);

  // Gain products with round half up
  assign px_rnd = (x_r * cfg.gain) + (SB+16)'(16384);
  assign gd_rnd = (delayed_r * cfg.gain) + (SB+16)'(16384);

  assign w_c = sat((SB+2)'(x_r) + (SB+2)'(gd_r));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_RDB;
      S_RDB:   state_nxt = S_INT;
      S_INT:   state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_OUT;
      S_OUT:   if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    wrapped_nxt = wrapped_r;
    if (ram_we) begin
      if (wr_idx_r == AW'(RING_DEPTH - 1)) begin
        wr_idx_nxt  = '0;
        wrapped_nxt = 1'b1;
      end else begin
        wr_idx_nxt = wr_idx_r + AW'(1);
      end
    end
    if (ram_we) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_idx_r    <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          x_r  <= in_tdata[SB-1:0];
          p2_r <= p2_c;
          // an entry counts only once written since reset
          va_r <= wrapped_r || (p1_c < wr_idx_r);
          vb_r <= wrapped_r || (p2_c < wr_idx_r);
        end
      end
      S_RDB: begin
        a_r  <= va_r ? signed'(rd_data) : '0;
        px_r <= px_rnd[SB+15:15];
      end
      S_INT: begin
        delayed_r <= acc_c[SB+7:8];
      end
      S_GAIN: begin
        gd_r <= gd_rnd[SB+15:15];
        y_r  <= sat((SB+2)'(delayed_r) - (SB+2)'(px_r));
      end
      S_OUT: begin
        if (slot_free) begin
          out_data_r <= y_r;
        end
      end
      default: ;
    endcase
  end

  // Write pointer never leaves the ring
  assert property (@(posedge clk) disable iff (!rst_n)
    wr_idx_r < AW'(RING_DEPTH - 1) || wr_idx_r == AW'(RING_DEPTH - 1))
    else $error("write pointer beyond ring depth");

  // An accepted sample starts the second tap read on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_RDB)
    else $error("accepted sample did not advance to second tap read");

  // Every write-back presents a result on the next cycle and frees the input
  assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> out_valid_r && state_r == S_IDLE)
    else $error("write-back without a result");

  // No input is taken between accept and write-back
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDB || state_r == S_INT || state_r == S_GAIN) |-> !in_tready)
    else $error("input ready while a sample is in flight");

endmodule

@@ test/aid_scoreboard_pkg.sv @@
// Scoreboard for the allpass interpolated delay unit: predicts and checks each sample.
package aid_scoreboard_pkg;
  import aid_pkg::*;

  localparam logic signed [23:0] SAMPLE_MAX   = 24'sh7FFFFF;
  localparam logic signed [23:0] SAMPLE_MIN   = 24'sh800000;
  localparam logic [19:0]        DELAY_MAX_Q8 = 20'd1048320;

  class allpass_scoreboard;
    logic signed [23:0] ring [4096];
    logic [11:0]        wr_ptr;
    logic [19:0]        delay_q8;
    logic signed [15:0] gain;
    logic signed [23:0] expected_q [$];
    int unsigned        mismatches;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_ptr     = '0;
      delay_q8   = DELAY_MIN_Q8;
      gain       = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_delay(logic [31:0] data);
      logic [19:0] raw;
      raw = data[19:0];
      if (raw < DELAY_MIN_Q8) delay_q8 = DELAY_MIN_Q8;
      else if (raw > DELAY_MAX_Q8) delay_q8 = DELAY_MAX_Q8;
      else delay_q8 = raw;
    endfunction

    function void set_gain(logic [31:0] data);
      logic signed [15:0] raw;
      raw = data[15:0];
      if (raw > GAIN_LIMIT) gain = GAIN_LIMIT;
      else if (raw < -GAIN_LIMIT) gain = -GAIN_LIMIT;
      else gain = raw;
    endfunction

    function logic signed [23:0] clip(longint v);
      if (v > SAMPLE_MAX) return SAMPLE_MAX;
      if (v < SAMPLE_MIN) return SAMPLE_MIN;
      return 24'(v);
    endfunction

    // Q1.15 product, rounded half up
    function longint gain_product(longint v);
      return (longint'(gain) * v + 16384) >>> 15;
    endfunction

    function void flag(string what, longint want, longint got);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void note_sample(logic signed [23:0] x);
      logic [11:0] whole;
      logic [11:0] tap_a;
      logic [11:0] tap_b;
      longint      frac;
      longint      near;
      longint      far;
      longint      delayed;
      whole   = delay_q8[19:8];
      frac    = longint'(delay_q8[7:0]);
      tap_a   = wr_ptr - whole;
      tap_b   = wr_ptr - whole - 12'd1;
      near    = longint'(ring[tap_a]);
      far     = longint'(ring[tap_b]);
      delayed = (near * (256 - frac) + far * frac + 128) >>> 8;
      expected_q.push_back(clip(delayed - gain_product(x)));
      ring[wr_ptr] = clip(x + gain_product(delayed));
      wr_ptr = wr_ptr + 12'd1;
    endfunction

    function void check_sample(logic signed [23:0] got);
      logic signed [23:0] want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("sample_out %0d arrived with nothing expected", got);
        return;
      end
      want = expected_q.pop_front();
      if (got !== want) flag("sample_out", want, got);
    endfunction

    function void check_reg(logic idx, logic [31:0] rd);
      logic signed [15:0] rd_gain;
      rd_gain = rd[15:0];
      if (idx == REG_DELAY) begin
        if (rd[19:0] !== delay_q8) flag("delay_q8 read-back", delay_q8, rd[19:0]);
      end else begin
        if (rd_gain !== gain) flag("feedback_gain read-back", gain, rd_gain);
      end
    endfunction
  endclass

endpackage

@@ test/allpass_interp_delay_unit_tb.sv @@
// Self-checking testbench of the allpass interpolated delay unit.
module allpass_interp_delay_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import aid_pkg::*;
  import aid_scoreboard_pkg::*;

  localparam int PHASES          = 8;
  localparam int PHASE_ITEMS     = 110;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT  = 4000;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;   // [23:0] sample_in
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [23:0] out_tdata;          // [23:0] sample_out
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Random idling on both streams; off for one whole phase
  bit idle_on      = 1'b1;
  // Raised by the stimulus, cleared by the sink once it starts holding off
  bit hold_off_req = 1'b0;
  int quiet_cycles = 0;

  allpass_scoreboard sb;

  always #5 clk = ~clk;

  allpass_interp_delay_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Monitor: check finished samples before noting new ones, so that an empty
  // store is never topped up by the sample accepted on the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_sample(out_tdata);
      if (in_tvalid && in_tready) sb.note_sample(in_tdata);
    end
  end

  // Watchdog: count edges on which no transaction of any kind moves
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sink: drop ready now and then; on request hold off for a long stretch so
  // that the output register fills and the unit stalls its input.
  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= !(idle_on && $urandom_range(99) < 6);
      end
    end
  end

  // Offer one sample and hold it until the transaction completes. Call on a
  // rising edge; returns on the accepting edge with valid still high.
  task automatic send_sample(input logic [23:0] x);
    if (idle_on && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    do @(posedge clk); while (!in_tready);
  endtask

  // Register write: setup cycle, access cycle, then the bus returns to idle
  task automatic reg_write(input logic idx, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx == REG_DELAY) sb.set_delay(data);
    else sb.set_gain(data);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Register read, compared with the clamped value the predictor holds
  task automatic reg_read_check(input logic idx);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.check_reg(idx, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [31:0] delay_word, input logic [31:0] gain_word);
    reg_write(REG_DELAY, delay_word);
    reg_write(REG_GAIN, gain_word);
    reg_read_check(REG_DELAY);
    reg_read_check(REG_GAIN);
  endtask

  // Stop offering, wait for every expected sample, then let the pipeline settle
  task automatic drain_samples();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly full-range noise, with full scale and small values mixed in
  function automatic logic [23:0] pick_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return {{16{r[7]}}, r[7:0]};
      default: return r[23:0];
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] delay_word;
    logic [31:0] gain_word;
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, then a few samples through the reset setting
    reg_read_check(REG_DELAY);
    reg_read_check(REG_GAIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(24'h000000);
    send_sample(24'h555555);
    drain_samples();

    // Delay below one sample clamps up, gain above the limit clamps down;
    // full-scale runs of either sign drive both sums into saturation.
    configure(32'd0, 32'h0000_7FFF);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MIN);
    send_sample(24'hAAAAAA);
    send_sample(24'h000001);
    send_sample(24'hFFFFFF);
    drain_samples();

    // One-and-a-half-sample delay with the most negative gain clamped up
    configure(32'h0000_0180, 32'h0000_8000);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(24'h000000);
    send_sample(24'h555555);
    drain_samples();

    // Delay beyond the ring clamps to the longest whole-sample delay
    configure(32'h000F_FFFF, 32'd31129);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(24'h000000);
    drain_samples();

    for (int ph = 0; ph < PHASES; ph++) begin
      gain_word = $urandom_range(62258);
      gain_word = gain_word - 32'd31129;
      case (ph)
        0: begin
          delay_word = $urandom_range(8, 1) * 256 + $urandom_range(255);
          gain_word  = $urandom();
        end
        1: delay_word = $urandom_range(32, 1) * 256 + $urandom_range(255);
        2: delay_word = $urandom_range(300, 1) * 256 + $urandom_range(255);
        3: begin
          delay_word = 32'(DELAY_MAX_Q8);
          gain_word  = -32'sd31129;
        end
        4: begin
          delay_word = $urandom();
          gain_word  = $urandom();
        end
        5: begin
          delay_word = 32'(DELAY_MIN_Q8);
          gain_word  = 32'd31129;
        end
        6: delay_word = $urandom_range(8, 1) * 256 + $urandom_range(255);
        default: delay_word = $urandom_range(64, 1) * 256 + $urandom_range(255);
      endcase
      configure(delay_word, gain_word);

      // One phase runs without idling; another holds the sink off at its start
      idle_on = (ph != 2);
      if (ph == 1) hold_off_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_sample());
      drain_samples();
    end

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
